// ===== design/sfrf_pkg.sv =====
// Package for the stereo frame ring FIFO: request codes, write status codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package sfrf_pkg;

	// Default sizes, handed to the top level parameters
	localparam int DEF_MAX_FRAMES  = 1024;
	localparam int DEF_SAMPLE_BITS = 32;
	localparam int DEF_MAX_READ    = 64;

	// Fixed port widths
	localparam int CAP_W     = 11;
	localparam int BURST_W   = 13;
	localparam int RDREQ_W   = 7;
	localparam int SAMPLE_W  = 32;
	localparam int TOTAL_W   = 32;
	localparam int QUEUED_W  = 11;

	// Capacity after reset, before clamping to the ring size
	localparam int CAP_RESET = 1024;

	// Request codes
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_FLUSH = 2'd2;

	// Write status / burst verdict
	typedef enum logic [1:0] {
		WS_NONE   = 2'd0,
		WS_ACCEPT = 2'd1,
		WS_DROP   = 2'd2,
		WS_REJECT = 2'd3
	} wstat_t;

	// Controller states
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_READ = 1'b1
	} ctrl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic item_take;  // input item accepted this cycle
		logic rd_beat;    // issue the next frame of a read
		logic cfg_ok;     // configuration write may complete
		logic busy;       // read sequence in progress
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic pipe_adv;   // result pipeline moves this cycle
		logic rd_last;    // current read beat is the last one
		logic rd_start;   // presented item is a non-empty read
	} stat_t;

endpackage

// ===== design/stereo_frame_ring_fifo.sv =====
// Top level of the stereo frame ring FIFO: controller plus datapath.
// Depends on sfrf_pkg, sfrf_ctrl and sfrf_dp.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------------
//  input    | in_valid / in_stall     | req_type, first_of_burst, burst_frames,
//           |                         | left_sample, right_sample, read_frames
//  output   | out_valid / out_stall   | out_left, out_right, zero_filled,
//           |                         | last_result, write_status, queued_frames,
//           |                         | dropped_total, underrun_total
//  config   | cfg_valid / cfg_ready   | cfg_data (capacity_frames)
//
// Write, flush and ignored items are taken singly. A read is taken, then its
// frames issue one per cycle unless out_stall holds the pipeline, through the
// single read port of the frame memory and the stage 1 and stage 2 registers.
// Reset is asynchronous; no clearing pass, the frame memory is not initialized.
// out_stall on a valid output freezes the whole result pipeline and stalls the input.
module stereo_frame_ring_fifo #(
	parameter int MAX_FRAMES  = sfrf_pkg::DEF_MAX_FRAMES,
	parameter int SAMPLE_BITS = sfrf_pkg::DEF_SAMPLE_BITS,
	parameter int MAX_READ    = sfrf_pkg::DEF_MAX_READ
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      req_type,
	input  logic                            first_of_burst,
	input  logic [sfrf_pkg::BURST_W-1:0]    burst_frames,
	input  logic [sfrf_pkg::SAMPLE_W-1:0]   left_sample,
	input  logic [sfrf_pkg::SAMPLE_W-1:0]   right_sample,
	input  logic [sfrf_pkg::RDREQ_W-1:0]    read_frames,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sfrf_pkg::CAP_W-1:0]      cfg_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [sfrf_pkg::SAMPLE_W-1:0]   out_left,
	output logic [sfrf_pkg::SAMPLE_W-1:0]   out_right,
	output logic                            zero_filled,
	output logic                            last_result,
	output logic [1:0]                      write_status,
	output logic [sfrf_pkg::QUEUED_W-1:0]   queued_frames,
	output logic [sfrf_pkg::TOTAL_W-1:0]    dropped_total,
	output logic [sfrf_pkg::TOTAL_W-1:0]    underrun_total
);

	sfrf_pkg::cmd_t  cmd;
	sfrf_pkg::stat_t stat;

	// Sequencer
	sfrf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cfg_ready (cfg_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Memory, pointers, counters, result pipeline
	sfrf_dp #(
		.MAX_FRAMES  (MAX_FRAMES),
		.SAMPLE_BITS (SAMPLE_BITS),
		.MAX_READ    (MAX_READ)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.req_type       (req_type),
		.first_of_burst (first_of_burst),
		.burst_frames   (burst_frames),
		.left_sample    (left_sample),
		.right_sample   (right_sample),
		.read_frames    (read_frames),
		.cfg_valid      (cfg_valid),
		.cfg_data       (cfg_data),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.out_left       (out_left),
		.out_right      (out_right),
		.zero_filled    (zero_filled),
		.last_result    (last_result),
		.write_status   (write_status),
		.queued_frames  (queued_frames),
		.dropped_total  (dropped_total),
		.underrun_total (underrun_total)
	);

	// A status result is the only result of its item and carries no samples
	a_status_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (write_status != sfrf_pkg::WS_NONE))
		|-> (last_result && !zero_filled && (out_left == '0) && (out_right == '0)))
		else $error("status result malformed");

	// Padding frames are all-zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && zero_filled) |-> ((out_left == '0) && (out_right == '0)))
		else $error("zero-filled frame carries data");

	// A read sequence ends only on its last beat
	a_read_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.busy && !(cmd.rd_beat && stat.rd_last)) |=> cmd.busy)
		else $error("read sequence ended early");

	// No item is taken while a read is being issued
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.busy |-> (!cmd.item_take && in_stall))
		else $error("item taken during read");

endmodule

// ===== design/sfrf_ctrl.sv =====
// Controller of the stereo frame ring FIFO: idle/read sequencer that takes
// items and steps read requests. Depends on sfrf_pkg.
module sfrf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              cfg_ready,
	input  sfrf_pkg::stat_t   stat,
	output sfrf_pkg::cmd_t    cmd
);

	sfrf_pkg::ctrl_state_t state_q, state_nx;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfrf_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state and commands
	always_comb begin
		state_nx  = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		cfg_ready = 1'b0;
		case (state_q)
			sfrf_pkg::ST_IDLE: begin
				in_stall      = !stat.pipe_adv;
				cfg_ready     = 1'b1;
				cmd.cfg_ok    = 1'b1;
				cmd.item_take = in_valid && stat.pipe_adv;
				if (cmd.item_take && stat.rd_start) begin
					state_nx = sfrf_pkg::ST_READ;
				end
			end
			sfrf_pkg::ST_READ: begin
				cmd.busy    = 1'b1;
				cmd.rd_beat = stat.pipe_adv;
				if (stat.pipe_adv && stat.rd_last) begin
					state_nx = sfrf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = sfrf_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/sfrf_dp.sv =====
// Datapath of the stereo frame ring FIFO: frame memory, ring pointers, burst
// tracking, counters and the two-stage result pipeline. Depends on sfrf_pkg.
module sfrf_dp #(
	parameter int MAX_FRAMES  = sfrf_pkg::DEF_MAX_FRAMES,
	parameter int SAMPLE_BITS = sfrf_pkg::DEF_SAMPLE_BITS,
	parameter int MAX_READ    = sfrf_pkg::DEF_MAX_READ
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sfrf_pkg::cmd_t                  cmd,
	output sfrf_pkg::stat_t                 stat,
	input  logic [1:0]                      req_type,
	input  logic                            first_of_burst,
	input  logic [sfrf_pkg::BURST_W-1:0]    burst_frames,
	input  logic [sfrf_pkg::SAMPLE_W-1:0]   left_sample,
	input  logic [sfrf_pkg::SAMPLE_W-1:0]   right_sample,
	input  logic [sfrf_pkg::RDREQ_W-1:0]    read_frames,
	input  logic                            cfg_valid,
	input  logic [sfrf_pkg::CAP_W-1:0]      cfg_data,
	input  logic                            out_stall,
	output logic                            out_valid,
	output logic [sfrf_pkg::SAMPLE_W-1:0]   out_left,
	output logic [sfrf_pkg::SAMPLE_W-1:0]   out_right,
	output logic                            zero_filled,
	output logic                            last_result,
	output logic [1:0]                      write_status,
	output logic [sfrf_pkg::QUEUED_W-1:0]   queued_frames,
	output logic [sfrf_pkg::TOTAL_W-1:0]    dropped_total,
	output logic [sfrf_pkg::TOTAL_W-1:0]    underrun_total
);

	localparam int IdxW   = $clog2(MAX_FRAMES);
	localparam int CntW   = $clog2(MAX_FRAMES + 1);
	localparam int RdW    = $clog2(MAX_READ + 1);
	localparam int CapRst = (sfrf_pkg::CAP_RESET > MAX_FRAMES) ? MAX_FRAMES
		: sfrf_pkg::CAP_RESET;
	localparam int TW     = sfrf_pkg::TOTAL_W;

	// Frame memory, {right, left}
	logic [2*SAMPLE_BITS-1:0] mem [MAX_FRAMES];

	// Ring and counter state
	logic [CntW-1:0]              cap_q, fill_q, staged_q;
	logic [IdxW-1:0]              wi_q, ri_q, wp_q;
	logic [TW-1:0]                drop_q, under_q;
	logic [sfrf_pkg::BURST_W-1:0] rem_q;
	sfrf_pkg::wstat_t             verdict_q;
	logic [RdW-1:0]               rd_n_q, rd_avail_q, rd_k_q;

	// Result pipeline
	logic                   vld_s1, vld_s2;
	logic [2*SAMPLE_BITS-1:0] mem_s1;
	logic                   use_mem_s1, zf_s1, last_s1, zf_s2, last_s2;
	sfrf_pkg::wstat_t       ws_s1, ws_s2;
	logic [CntW-1:0]        fill_s1, fill_s2;
	logic [TW-1:0]          drop_s1, drop_s2, under_s1, under_s2;
	logic [SAMPLE_BITS-1:0] left_s2, right_s2;

	// Decode
	logic adv, is_wr, is_rd, clr, cfg_we;
	logic [CntW-1:0] cap_nx;

	assign adv    = !vld_s2 || !out_stall;
	assign is_wr  = cmd.item_take && (req_type == sfrf_pkg::REQ_WRITE);
	assign is_rd  = cmd.item_take && stat.rd_start;
	assign cfg_we = cfg_valid && cmd.cfg_ok;
	assign clr    = cfg_we || (cmd.item_take && (req_type == sfrf_pkg::REQ_FLUSH));

	// Capacity clamp: zero becomes one, above the ring size becomes the ring size
	always_comb begin
		if (cfg_data == '0) begin
			cap_nx = CntW'(1);
		end else if (32'(cfg_data) > 32'(MAX_FRAMES)) begin
			cap_nx = CntW'(MAX_FRAMES);
		end else begin
			cap_nx = CntW'(cfg_data);
		end
	end

	// Write burst evaluation
	logic                         w_zero, w_active, w_store, w_end, w_drop_add, w_acc_end;
	logic [sfrf_pkg::BURST_W-1:0] w_rem, w_rem_nx;
	sfrf_pkg::wstat_t             w_ver, w_status;
	logic [IdxW-1:0]              w_wp, w_wp_nx;
	logic [CntW-1:0]              w_staged, w_staged_nx, room, fill_after;
	logic [TW:0]                  drop_sum;
	logic [TW-1:0]                drop_nx;

	always_comb begin
		room     = cap_q - fill_q;
		w_zero   = first_of_burst && (burst_frames == '0);
		w_rem    = first_of_burst ? burst_frames : rem_q;
		w_wp     = first_of_burst ? wi_q : wp_q;
		w_staged = first_of_burst ? '0 : staged_q;
		if (!first_of_burst) begin
			w_ver = verdict_q;
		end else if (32'(burst_frames) > 32'(cap_q)) begin
			w_ver = sfrf_pkg::WS_REJECT;
		end else if (32'(burst_frames) > 32'(room)) begin
			w_ver = sfrf_pkg::WS_DROP;
		end else begin
			w_ver = sfrf_pkg::WS_ACCEPT;
		end
		w_active   = !w_zero && (first_of_burst || (rem_q != '0));
		w_store    = w_active && (w_ver == sfrf_pkg::WS_ACCEPT);
		w_staged_nx = w_staged + CntW'(w_store);
		if (!w_store) begin
			w_wp_nx = w_wp;
		end else if ((CntW'(w_wp) + CntW'(1)) == cap_q) begin
			w_wp_nx = '0;
		end else begin
			w_wp_nx = w_wp + IdxW'(1);
		end
		w_rem_nx   = w_rem - sfrf_pkg::BURST_W'(1);
		w_end      = w_active && (w_rem_nx == '0);
		w_acc_end  = w_end && (w_ver == sfrf_pkg::WS_ACCEPT);
		w_drop_add = first_of_burst && !w_zero && (w_ver == sfrf_pkg::WS_DROP);
		w_status   = w_zero ? sfrf_pkg::WS_REJECT : w_ver;
		fill_after = w_acc_end ? (fill_q + w_staged_nx) : fill_q;
		// saturating drop count
		drop_sum   = {1'b0, drop_q} + (TW+1)'(burst_frames);
		if (!w_drop_add) begin
			drop_nx = drop_q;
		end else if (drop_sum[TW]) begin
			drop_nx = '1;
		end else begin
			drop_nx = drop_sum[TW-1:0];
		end
	end

	// Read request evaluation
	logic [RdW-1:0] rd_n, rd_avail, ri_step;
	logic [TW:0]    under_sum;
	logic           beat_mem;
	logic [IdxW-1:0] ri_inc;

	always_comb begin
		if (32'(read_frames) > 32'(MAX_READ)) begin
			rd_n = RdW'(MAX_READ);
		end else begin
			rd_n = RdW'(read_frames);
		end
		rd_avail  = (32'(fill_q) < 32'(rd_n)) ? RdW'(fill_q) : rd_n;
		ri_step   = rd_n - rd_avail;
		under_sum = {1'b0, under_q} + (TW+1)'(ri_step);
		beat_mem  = rd_k_q < rd_avail_q;
		ri_inc    = ((CntW'(ri_q) + CntW'(1)) == cap_q) ? '0 : ri_q + IdxW'(1);
	end

	assign stat.pipe_adv = adv;
	assign stat.rd_last  = rd_k_q == (rd_n_q - RdW'(1));
	assign stat.rd_start = (req_type == sfrf_pkg::REQ_READ) && (read_frames != '0);

	// Ring state, counters and burst tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q      <= CntW'(CapRst);
			wi_q       <= '0;
			ri_q       <= '0;
			wp_q       <= '0;
			fill_q     <= '0;
			staged_q   <= '0;
			drop_q     <= '0;
			under_q    <= '0;
			rem_q      <= '0;
			verdict_q  <= sfrf_pkg::WS_NONE;
			rd_n_q     <= '0;
			rd_avail_q <= '0;
			rd_k_q     <= '0;
		end else if (clr) begin
			if (cfg_we) begin
				cap_q <= cap_nx;
			end
			wi_q      <= '0;
			ri_q      <= '0;
			wp_q      <= '0;
			fill_q    <= '0;
			staged_q  <= '0;
			drop_q    <= '0;
			under_q   <= '0;
			rem_q     <= '0;
			verdict_q <= sfrf_pkg::WS_NONE;
		end else begin
			if (is_wr && w_zero) begin
				rem_q     <= '0;
				verdict_q <= sfrf_pkg::WS_NONE;
				staged_q  <= '0;
			end else if (is_wr && w_active) begin
				rem_q     <= w_rem_nx;
				verdict_q <= w_end ? sfrf_pkg::WS_NONE : w_ver;
				staged_q  <= w_end ? '0 : w_staged_nx;
				wp_q      <= w_wp_nx;
				drop_q    <= drop_nx;
				fill_q    <= fill_after;
				if (w_acc_end) begin
					wi_q <= w_wp_nx;
				end
			end
			if (is_rd) begin
				fill_q     <= fill_q - CntW'(rd_avail);
				under_q    <= under_sum[TW] ? '1 : under_sum[TW-1:0];
				rd_n_q     <= rd_n;
				rd_avail_q <= rd_avail;
				rd_k_q     <= '0;
			end
			if (cmd.rd_beat) begin
				rd_k_q <= rd_k_q + RdW'(1);
				if (beat_mem) begin
					ri_q <= ri_inc;
				end
			end
		end
	end

	// Frame memory write and registered read
	always_ff @(posedge clk) begin
		if (is_wr && w_store) begin
			mem[w_wp] <= {right_sample[SAMPLE_BITS-1:0], left_sample[SAMPLE_BITS-1:0]};
		end
		if (cmd.rd_beat && beat_mem) begin
			mem_s1 <= mem[ri_q];
		end
	end

	// Pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= cmd.rd_beat || (is_wr && (w_zero || w_end));
			vld_s2 <= vld_s1;
		end
	end

	// Pipeline payload: stage 1 result description, stage 2 output register
	always_ff @(posedge clk) begin
		if (adv) begin
			if (cmd.rd_beat) begin
				use_mem_s1 <= beat_mem;
				zf_s1      <= !beat_mem;
				last_s1    <= stat.rd_last;
				ws_s1      <= sfrf_pkg::WS_NONE;
				fill_s1    <= fill_q;
				drop_s1    <= drop_q;
				under_s1   <= under_q;
			end else begin
				use_mem_s1 <= 1'b0;
				zf_s1      <= 1'b0;
				last_s1    <= 1'b1;
				ws_s1      <= w_status;
				fill_s1    <= fill_after;
				drop_s1    <= drop_nx;
				under_s1   <= under_q;
			end
			left_s2  <= use_mem_s1 ? mem_s1[SAMPLE_BITS-1:0] : '0;
			right_s2 <= use_mem_s1 ? mem_s1[2*SAMPLE_BITS-1:SAMPLE_BITS] : '0;
			zf_s2    <= zf_s1;
			last_s2  <= last_s1;
			ws_s2    <= ws_s1;
			fill_s2  <= fill_s1;
			drop_s2  <= drop_s1;
			under_s2 <= under_s1;
		end
	end

	// Output ports
	assign out_valid      = vld_s2;
	assign out_left       = sfrf_pkg::SAMPLE_W'(left_s2);
	assign out_right      = sfrf_pkg::SAMPLE_W'(right_s2);
	assign zero_filled    = zf_s2;
	assign last_result    = last_s2;
	assign write_status   = ws_s2;
	assign queued_frames  = sfrf_pkg::QUEUED_W'(fill_s2);
	assign dropped_total  = drop_s2;
	assign underrun_total = under_s2;

endmodule

// ===== dv/sfrf_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the stereo frame ring FIFO: watches the input, config and result channels,
// keeps its own copy of ring, pointers and counters, and compares every result item.
// Depends on sfrf_pkg.
module sfrf_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [1:0]                     req_type,
	input  logic                           first_of_burst,
	input  logic [sfrf_pkg::BURST_W-1:0]   burst_frames,
	input  logic [sfrf_pkg::SAMPLE_W-1:0]  left_sample,
	input  logic [sfrf_pkg::SAMPLE_W-1:0]  right_sample,
	input  logic [sfrf_pkg::RDREQ_W-1:0]   read_frames,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [sfrf_pkg::CAP_W-1:0]     cfg_data,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [sfrf_pkg::SAMPLE_W-1:0]  out_left,
	input  logic [sfrf_pkg::SAMPLE_W-1:0]  out_right,
	input  logic                           zero_filled,
	input  logic                           last_result,
	input  logic [1:0]                     write_status,
	input  logic [sfrf_pkg::QUEUED_W-1:0]  queued_frames,
	input  logic [sfrf_pkg::TOTAL_W-1:0]   dropped_total,
	input  logic [sfrf_pkg::TOTAL_W-1:0]   underrun_total,
	output int                             fail_count,
	output int                             pending
);

	typedef struct packed {
		logic [31:0]      left;
		logic [31:0]      right;
		logic             zf;
		logic             is_last;
		sfrf_pkg::wstat_t status;
		logic [10:0]      queued;
		logic [31:0]      dropped;
		logic [31:0]      underrun;
	} frame_result_t;

	// Expected result items, oldest first
	frame_result_t frame_results_q[$];

	// Predicted ring state
	logic [63:0]      ring_mem [0:sfrf_pkg::DEF_MAX_FRAMES-1];
	int               cap = (sfrf_pkg::CAP_RESET > sfrf_pkg::DEF_MAX_FRAMES)
		? sfrf_pkg::DEF_MAX_FRAMES : sfrf_pkg::CAP_RESET;
	int               wr_ptr = 0;
	int               rd_ptr = 0;
	int               fill = 0;
	int               burst_left = 0;
	int               burst_staged = 0;
	logic [31:0]      drop_cnt = '0;
	logic [31:0]      under_cnt = '0;
	sfrf_pkg::wstat_t burst_verdict = sfrf_pkg::WS_NONE;

	initial begin
		fail_count = 0;
		pending = 0;
	end

	function automatic logic [31:0] sat_sum(logic [31:0] a, int unsigned b);
		logic [32:0] s;
		s = {1'b0, a} + 33'(b);
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	// Pointers, counters and any open burst back to empty
	task automatic clear_ring();
		wr_ptr = 0;
		rd_ptr = 0;
		fill = 0;
		drop_cnt = '0;
		under_cnt = '0;
		burst_left = 0;
		burst_staged = 0;
		burst_verdict = sfrf_pkg::WS_NONE;
	endtask

	task automatic set_capacity(logic [sfrf_pkg::CAP_W-1:0] v);
		int c;
		c = v;
		if (c == 0)
			c = 1;
		if (c > sfrf_pkg::DEF_MAX_FRAMES)
			c = sfrf_pkg::DEF_MAX_FRAMES;
		cap = c;
		clear_ring();
	endtask

	// Counters in a result are the values after the whole step
	task automatic push_result(logic [63:0] frame, logic zf, logic is_last,
			sfrf_pkg::wstat_t st);
		frame_result_t r;
		r.left = frame[63:32];
		r.right = frame[31:0];
		r.zf = zf;
		r.is_last = is_last;
		r.status = st;
		r.queued = 11'(fill);
		r.dropped = drop_cnt;
		r.underrun = under_cnt;
		frame_results_q.push_back(r);
	endtask

	// Burst verdict is taken on the first item; frames commit on the last one
	task automatic predict_write(logic is_first, logic [sfrf_pkg::BURST_W-1:0] len_in,
			logic [31:0] l, logic [31:0] r);
		int len;
		len = len_in;
		if (is_first) begin
			burst_staged = 0;
			burst_left = 0;
			burst_verdict = sfrf_pkg::WS_NONE;
			if (len == 0) begin
				push_result(64'd0, 1'b0, 1'b1, sfrf_pkg::WS_REJECT);
				return;
			end
			burst_left = len;
			if (len > cap)
				burst_verdict = sfrf_pkg::WS_REJECT;
			else if (len > cap - fill) begin
				drop_cnt = sat_sum(drop_cnt, len);
				burst_verdict = sfrf_pkg::WS_DROP;
			end else
				burst_verdict = sfrf_pkg::WS_ACCEPT;
		end else if (burst_left == 0)
			return;

		if (burst_verdict == sfrf_pkg::WS_ACCEPT) begin
			ring_mem[(wr_ptr + burst_staged) % cap] = {l, r};
			burst_staged++;
		end
		burst_left--;
		if (burst_left == 0) begin
			if (burst_verdict == sfrf_pkg::WS_ACCEPT) begin
				wr_ptr = (wr_ptr + burst_staged) % cap;
				fill += burst_staged;
			end
			push_result(64'd0, 1'b0, 1'b1, burst_verdict);
			burst_staged = 0;
			burst_verdict = sfrf_pkg::WS_NONE;
		end
	endtask

	// Queued frames first, then zero padding for the shortfall
	task automatic predict_read(logic [sfrf_pkg::RDREQ_W-1:0] req);
		logic [63:0] frames [sfrf_pkg::DEF_MAX_READ];
		int          n;
		int          avail;
		n = req;
		if (n == 0)
			return;
		if (n > sfrf_pkg::DEF_MAX_READ)
			n = sfrf_pkg::DEF_MAX_READ;
		avail = (fill < n) ? fill : n;
		for (int k = 0; k < avail; k++) begin
			frames[k] = ring_mem[rd_ptr % cap];
			rd_ptr = (rd_ptr % cap + 1) % cap;
		end
		fill -= avail;
		if (avail < n)
			under_cnt = sat_sum(under_cnt, n - avail);
		for (int k = 0; k < n; k++)
			push_result((k < avail) ? frames[k] : 64'd0, k >= avail, k == n - 1,
				sfrf_pkg::WS_NONE);
	endtask

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	// Results are checked before new items are predicted; latency keeps them apart
	always @(posedge clk or negedge arst_n) begin
		frame_result_t exp_r;
		if (!arst_n) begin
			cap = (sfrf_pkg::CAP_RESET > sfrf_pkg::DEF_MAX_FRAMES)
				? sfrf_pkg::DEF_MAX_FRAMES : sfrf_pkg::CAP_RESET;
			clear_ring();
			frame_results_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (frame_results_q.size() == 0) begin
					$error("result item with nothing expected");
					fail_count++;
				end else begin
					exp_r = frame_results_q.pop_front();
					check_field("out_left", exp_r.left, out_left);
					check_field("out_right", exp_r.right, out_right);
					check_field("zero_filled", 32'(exp_r.zf), 32'(zero_filled));
					check_field("last_result", 32'(exp_r.is_last), 32'(last_result));
					check_field("write_status", 32'(exp_r.status), 32'(write_status));
					check_field("queued_frames", 32'(exp_r.queued), 32'(queued_frames));
					check_field("dropped_total", exp_r.dropped, dropped_total);
					check_field("underrun_total", exp_r.underrun, underrun_total);
				end
			end
			if (cfg_valid && cfg_ready)
				set_capacity(cfg_data);
			if (in_valid && !in_stall) begin
				case (req_type)
					sfrf_pkg::REQ_WRITE: predict_write(first_of_burst, burst_frames,
						left_sample, right_sample);
					sfrf_pkg::REQ_READ:  predict_read(read_frames);
					sfrf_pkg::REQ_FLUSH: clear_ring();
					default:   ;
				endcase
			end
		end
		pending = frame_results_q.size();
	end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the stereo frame ring FIFO: clock, reset, directed and random stimulus,
// random result stalls and the final verdict. Depends on sfrf_pkg, the block and sfrf_checker.
module tb_top;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int         CYCLE_LIMIT = 1_500_000;
	localparam int         PHASE_ITEMS = 18;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [1:0]                    req_type = sfrf_pkg::REQ_WRITE;
	logic                          first_of_burst = 1'b0;
	logic [sfrf_pkg::BURST_W-1:0]  burst_frames = '0;
	logic [sfrf_pkg::SAMPLE_W-1:0] left_sample = '0;
	logic [sfrf_pkg::SAMPLE_W-1:0] right_sample = '0;
	logic [sfrf_pkg::RDREQ_W-1:0]  read_frames = '0;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [sfrf_pkg::CAP_W-1:0]    cfg_data = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [sfrf_pkg::SAMPLE_W-1:0] out_left;
	logic [sfrf_pkg::SAMPLE_W-1:0] out_right;
	logic                          zero_filled;
	logic                          last_result;
	logic [1:0]                    write_status;
	logic [sfrf_pkg::QUEUED_W-1:0] queued_frames;
	logic [sfrf_pkg::TOTAL_W-1:0]  dropped_total;
	logic [sfrf_pkg::TOTAL_W-1:0]  underrun_total;
	int                            fail_count;
	int                            pending;

	int cycles = 0;
	int stall_left = 0;
	bit quiet_out = 1'b0;
	bit quiet_in = 1'b0;
	int items_sent;

	stereo_frame_ring_fifo i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.first_of_burst (first_of_burst),
		.burst_frames   (burst_frames),
		.left_sample    (left_sample),
		.right_sample   (right_sample),
		.read_frames    (read_frames),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_left       (out_left),
		.out_right      (out_right),
		.zero_filled    (zero_filled),
		.last_result    (last_result),
		.write_status   (write_status),
		.queued_frames  (queued_frames),
		.dropped_total  (dropped_total),
		.underrun_total (underrun_total)
	);

	sfrf_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.first_of_burst (first_of_burst),
		.burst_frames   (burst_frames),
		.left_sample    (left_sample),
		.right_sample   (right_sample),
		.read_frames    (read_frames),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_left       (out_left),
		.out_right      (out_right),
		.zero_filled    (zero_filled),
		.last_result    (last_result),
		.write_status   (write_status),
		.queued_frames  (queued_frames),
		.dropped_total  (dropped_total),
		.underrun_total (underrun_total),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// Result-side back-pressure: mostly short stalls, a few long, with quiet stretches
	always @(posedge clk) begin
		if ($urandom_range(0, 149) == 0)
			quiet_out = !quiet_out;
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (quiet_out || $urandom_range(0, 99) < 70)
			out_stall <= 1'b0;
		else begin
			out_stall <= 1'b1;
			stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		end
	end

	// One input item: optional gap, then hold until taken; stall is sampled mid-cycle
	task automatic send_item(logic [1:0] rt, logic fb, logic [sfrf_pkg::BURST_W-1:0] len,
			logic [sfrf_pkg::SAMPLE_W-1:0] l, logic [sfrf_pkg::SAMPLE_W-1:0] r,
			logic [sfrf_pkg::RDREQ_W-1:0] rd);
		int   gap;
		logic stl;
		if ($urandom_range(0, 19) == 0)
			quiet_in = !quiet_in;
		gap = 0;
		if (!quiet_in && $urandom_range(0, 99) >= 60)
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 24) : $urandom_range(1, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		first_of_burst <= fb;
		burst_frames <= len;
		left_sample <= l;
		right_sample <= r;
		read_frames <= rd;
		do begin
			@(negedge clk);
			stl = in_stall;
			@(posedge clk);
		end while (stl);
	endtask

	task automatic send_read(logic [sfrf_pkg::RDREQ_W-1:0] rd);
		send_item(sfrf_pkg::REQ_READ, 1'($urandom), 13'($urandom), $urandom, $urandom, rd);
	endtask

	// Whole burst, random frames
	task automatic send_burst(int len);
		for (int k = 0; k < len; k++)
			send_item(sfrf_pkg::REQ_WRITE, k == 0, (k == 0) ? 13'(len) : 13'($urandom),
				$urandom, $urandom, 7'($urandom));
	endtask

	// Drain: nothing expected, then room for items that give no result
	task automatic wait_idle();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_capacity(logic [sfrf_pkg::CAP_W-1:0] v);
		logic rdy;
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do begin
			@(negedge clk);
			rdy = cfg_ready;
			@(posedge clk);
		end while (!rdy);
		cfg_valid <= 1'b0;
	endtask

	// Mostly complete bursts and small reads; some noise and broken bursts
	task automatic random_op(int cap_now);
		int r;
		int len;
		int lim;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			lim = (cap_now < 6) ? cap_now : 6;
			len = $urandom_range(1, lim);
			if ($urandom_range(0, 9) >= 7) begin
				// longer bursts, over capacity where that stays short
				if (cap_now <= 16)
					len = cap_now + $urandom_range(1, 4);
				else
					len = $urandom_range(1, 24);
			end
			send_burst(len);
			items_sent += len;
		end else if (r < 80) begin
			send_read(($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
				: 7'($urandom_range(1, 8)));
			items_sent++;
		end else if (r < 88) begin
			// burst header of any length, left open after a few frames
			send_item(sfrf_pkg::REQ_WRITE, 1'b1, 13'($urandom), $urandom, $urandom,
				7'($urandom));
			repeat ($urandom_range(0, 2))
				send_item(sfrf_pkg::REQ_WRITE, 1'b0, 13'($urandom), $urandom, $urandom,
					7'($urandom));
			items_sent++;
		end else if (r < 93) begin
			send_item(sfrf_pkg::REQ_FLUSH, 1'($urandom), 13'($urandom), $urandom, $urandom,
				7'($urandom));
			items_sent++;
		end else if (r < 97)
			send_item(REQ_UNUSED, 1'($urandom), 13'($urandom), $urandom, $urandom, 7'($urandom));
		else
			send_item(sfrf_pkg::REQ_WRITE, 1'b0, 13'($urandom), $urandom, $urandom,
				7'($urandom));
	endtask

	initial begin
		int phase_caps [5];
		phase_caps = '{5, 16, 1024, 2, 7};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset capacity of 1024
		send_read(7'd0);                               // no result
		send_read(7'd1);                               // underrun on empty ring
		send_item(sfrf_pkg::REQ_WRITE, 1'b1, 13'd0, '1, '1, '1); // zero-length burst
		send_item(sfrf_pkg::REQ_WRITE, 1'b1, 13'd3, 32'h0, 32'hFFFF_FFFF, 7'd0);
		send_item(sfrf_pkg::REQ_WRITE, 1'b0, 13'd0, 32'hFFFF_FFFF, 32'h0, 7'd0);
		send_item(sfrf_pkg::REQ_WRITE, 1'b0, '1, $urandom, $urandom, 7'd0);
		send_item(sfrf_pkg::REQ_WRITE, 1'b0, 13'd2, $urandom, $urandom, 7'd0); // stray frame
		send_item(REQ_UNUSED, 1'b1, 13'd1, $urandom, $urandom, 7'd1); // ignored type
		send_read(7'd127);                             // saturates to the read limit
		send_item(sfrf_pkg::REQ_WRITE, 1'b1, 13'd8191, $urandom, $urandom, 7'd0); // too long
		send_item(sfrf_pkg::REQ_WRITE, 1'b1, 13'd4, $urandom, $urandom, 7'd0); // abandons it
		send_burst(1);                                 // abandons accepted partial burst
		send_read(7'd2);
		send_burst(2);
		send_item(sfrf_pkg::REQ_FLUSH, 1'b0, 13'd0, '0, '0, 7'd0);
		send_read(7'd1);

		// Smallest ring: accept, drop on full, reject over capacity
		write_capacity(11'd0);
		send_burst(1);
		send_burst(1);
		send_burst(2);
		send_read(7'd2);

		// Above the ring size clamps to the largest
		write_capacity(11'd2047);
		send_burst(3);
		send_read(7'd4);

		// Random phases over several capacities
		foreach (phase_caps[p]) begin
			write_capacity(11'(phase_caps[p]));
			items_sent = 0;
			while (items_sent < PHASE_ITEMS)
				random_op(phase_caps[p]);
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
